@@ rtl/hkp_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the keyframe path unit.
// No dependencies.
package hkp_pkg;

   localparam int MAX_KEYS_DEFAULT  = 16;
   localparam int FRAC_BITS_DEFAULT = 16;

   // command codes
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_EVAL   = 2'd2;

   localparam logic signed [63:0] INT32_MAX_64 = 64'sd2147483647;
   localparam logic signed [63:0] INT32_MIN_64 = -64'sd2147483648;

   // one keyframe's point and tangents, as held in the key data memory
   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] out_tan_x;
      logic signed [31:0] out_tan_y;
      logic signed [31:0] in_tan_x;
      logic signed [31:0] in_tan_y;
   } key_data_type;

endpackage

@@ rtl/hkp_channels.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces of the keyframe path unit.
// No dependencies.
interface hkp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [31:0] key_time;
   logic signed [31:0] key_x;
   logic signed [31:0] key_y;
   logic signed [31:0] out_tan_x;
   logic signed [31:0] out_tan_y;
   logic signed [31:0] in_tan_x;
   logic signed [31:0] in_tan_y;
   logic signed [31:0] frame;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;

   modport source (output valid, command, key_time, key_x, key_y, out_tan_x, out_tan_y,
                   in_tan_x, in_tan_y, frame, pos_x, pos_y, input ready);
   modport sink (input valid, command, key_time, key_x, key_y, out_tan_x, out_tan_y,
                 in_tan_x, in_tan_y, frame, pos_x, pos_y, output ready);
endinterface

interface hkp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic               complete;
   logic               table_full;

   modport source (output valid, out_x, out_y, complete, table_full, input ready);
   modport sink (input valid, out_x, out_y, complete, table_full, output ready);
endinterface

@@ rtl/hermite_keyframe_path_unit.sv @@
`timescale 1ns / 1ps
// Keyframe path unit: one beat in, one beat out, one request in flight at a time.
// Clear, append, an unused code or an empty table go straight to the result register; an
// evaluate first scans key times from key 0 and stops there, at the last key or at a
// segment i, which then takes a fraction divide, key fetch and 15-step blend.
// Next request is taken the cycle after the result loads. Sync active-high reset
// empties the table and drops the result.
module hermite_keyframe_path_unit #(
   parameter int MAX_KEYS  = hkp_pkg::MAX_KEYS_DEFAULT,
   parameter int FRAC_BITS = hkp_pkg::FRAC_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   hkp_req_if.sink   req_if,
   hkp_rsp_if.source rsp_if
);

   localparam int IW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a request beat
   localparam logic [2:0] ST_T0    = 3'd1;  // time of key 0 arriving
   localparam logic [2:0] ST_TN    = 3'd2;  // time of key i+1 arriving
   localparam logic [2:0] ST_DIV   = 3'd3;  // fraction divide, key data fetch
   localparam logic [2:0] ST_BLEND = 3'd4;  // basis and blend
   localparam logic [2:0] ST_SEND  = 3'd5;  // result waits for the output register

   logic [2:0]               state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [IW-1:0]            idx_ff, idx_in;
   logic [1:0]               fetch_ff, fetch_in;
   logic signed [31:0]       frame_ff, tcur_ff, tcur_in;
   hkp_pkg::key_data_type    key0_ff;
   logic signed [31:0]       p1_x_ff, p1_y_ff;
   logic signed [31:0]       res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                     res_done_ff, res_done_in, res_full_ff, res_full_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]       rsp_x_ff, rsp_y_ff;
   logic                     rsp_done_ff, rsp_full_ff;
   logic                     accept, load_rsp;

   // memory ports
   logic                     wr_en;
   logic [IW-1:0]            t_addr, d_addr;
   logic signed [31:0]       t_rdata;
   hkp_pkg::key_data_type    d_rdata, wr_data;

   // divider and blend
   logic                     div_start, div_busy, blend_start, blend_done;
   logic [32:0]              div_num, div_den;
   logic [FRAC_BITS-1:0]     frac;
   logic signed [31:0]       blend_x, blend_y;
   logic [CW:0]              next_pair;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   assign wr_en = accept && (req_if.command == hkp_pkg::CMD_APPEND)
                  && (count_ff < CW'(MAX_KEYS));
   assign wr_data = '{point_x: req_if.key_x, point_y: req_if.key_y,
                      out_tan_x: req_if.out_tan_x, out_tan_y: req_if.out_tan_y,
                      in_tan_x: req_if.in_tan_x, in_tan_y: req_if.in_tan_y};

   // segment end index after stepping the scan forward
   assign next_pair = (CW+1)'(idx_ff) + (CW+1)'(2);

   // fraction operands; frame >= t_i and t_i+1 > frame, so the numerator is non-negative and the denominator positive
   assign div_num = 33'($signed({frame_ff[31], frame_ff}) - $signed({tcur_ff[31], tcur_ff}));
   assign div_den = 33'($signed({t_rdata[31], t_rdata}) - $signed({tcur_ff[31], tcur_ff}));

   assign load_rsp = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      fetch_in    = fetch_ff;
      tcur_in     = tcur_ff;
      res_x_in    = res_x_ff;
      res_y_in    = res_y_ff;
      res_done_in = res_done_ff;
      res_full_in = res_full_ff;
      t_addr      = '0;
      d_addr      = idx_ff;
      div_start   = 1'b0;
      blend_start = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_x_in    = '0;
               res_y_in    = '0;
               res_done_in = 1'b0;
               res_full_in = 1'b0;
               idx_in      = '0;
               state_in    = ST_SEND;
               case (req_if.command)
                  hkp_pkg::CMD_CLEAR: count_in = '0;
                  hkp_pkg::CMD_APPEND: begin
                     if (count_ff < CW'(MAX_KEYS)) begin
                        count_in = count_ff + CW'(1);
                     end else begin
                        res_full_in = 1'b1;
                     end
                  end
                  hkp_pkg::CMD_EVAL: begin
                     res_x_in = req_if.pos_x;
                     res_y_in = req_if.pos_y;
                     if (count_ff == '0) begin
                        res_done_in = 1'b1;
                     end else begin
                        state_in = ST_T0;
                     end
                  end
                  default: state_in = ST_SEND;
               endcase
            end
         end
         ST_T0: begin
            tcur_in = t_rdata;
            if (frame_ff < t_rdata) begin
               state_in = ST_SEND;
            end else if (count_ff == CW'(1)) begin
               res_done_in = 1'b1;
               state_in    = ST_SEND;
            end else begin
               t_addr   = IW'(1);
               state_in = ST_TN;
            end
         end
         ST_TN: begin
            if (t_rdata > frame_ff) begin
               // segment found: start the fraction and fetch key i
               div_start = 1'b1;
               d_addr    = idx_ff;
               fetch_in  = '0;
               state_in  = ST_DIV;
            end else begin
               tcur_in = t_rdata;
               idx_in  = idx_ff + IW'(1);
               if (next_pair >= (CW+1)'(count_ff)) begin
                  res_done_in = 1'b1;
                  state_in    = ST_SEND;
               end else begin
                  t_addr = next_pair[IW-1:0];
               end
            end
         end
         ST_DIV: begin
            if (fetch_ff == 2'd0) begin
               d_addr   = idx_ff + IW'(1);
               fetch_in = 2'd1;
            end else if (fetch_ff == 2'd1) begin
               fetch_in = 2'd2;
            end else if (!div_busy) begin
               blend_start = 1'b1;
               state_in    = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (blend_done) begin
               res_x_in = blend_x;
               res_y_in = blend_y;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         fetch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         fetch_ff     <= fetch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tcur_ff     <= tcur_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_done_ff <= res_done_in;
      res_full_ff <= res_full_in;
      if (accept) begin
         frame_ff <= req_if.frame;
      end
      if (state_ff == ST_DIV && fetch_ff == 2'd0) begin
         key0_ff <= d_rdata;
      end
      if (state_ff == ST_DIV && fetch_ff == 2'd1) begin
         p1_x_ff <= d_rdata.point_x;
         p1_y_ff <= d_rdata.point_y;
      end
      if (load_rsp) begin
         rsp_x_ff    <= res_x_ff;
         rsp_y_ff    <= res_y_ff;
         rsp_done_ff <= res_done_ff;
         rsp_full_ff <= res_full_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_x      = rsp_x_ff;
   assign rsp_if.out_y      = rsp_y_ff;
   assign rsp_if.complete   = rsp_done_ff;
   assign rsp_if.table_full = rsp_full_ff;

   hkp_key_store #(.MAX_KEYS(MAX_KEYS), .IW(IW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_time (req_if.key_time),
      .wr_data (wr_data),
      .t_addr  (t_addr),
      .t_rdata (t_rdata),
      .d_addr  (d_addr),
      .d_rdata (d_rdata)
   );

   hkp_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (frac)
   );

   hkp_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock (clock),
      .reset (reset),
      .start (blend_start),
      .t     (frac),
      .key0  (key0_ff),
      .p1_x  (p1_x_ff),
      .p1_y  (p1_y_ff),
      .done  (blend_done),
      .res_x (blend_x),
      .res_y (blend_y)
   );

endmodule

@@ rtl/hkp_key_store.sv @@
`timescale 1ns / 1ps
// Keyframe memories: key times and key data, one write and one registered read each.
// Depends on hkp_pkg.
module hkp_key_store #(
   parameter int MAX_KEYS = hkp_pkg::MAX_KEYS_DEFAULT,
   parameter int IW       = $clog2(MAX_KEYS)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IW-1:0]        wr_addr,
   input  logic signed [31:0]   wr_time,
   input  hkp_pkg::key_data_type wr_data,
   input  logic [IW-1:0]        t_addr,
   output logic signed [31:0]   t_rdata,
   input  logic [IW-1:0]        d_addr,
   output hkp_pkg::key_data_type d_rdata
);

   logic signed [31:0]    time_mem [MAX_KEYS];
   hkp_pkg::key_data_type data_mem [MAX_KEYS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= wr_time;
      end
      t_rdata <= time_mem[t_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         data_mem[wr_addr] <= wr_data;
      end
      d_rdata <= data_mem[d_addr];
   end

endmodule

@@ rtl/hkp_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider for the segment fraction, one quotient bit per cycle.
// Depends on hkp_pkg.
module hkp_divider #(
   parameter int FRAC_BITS = hkp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [32:0]          dividend,
   input  logic [32:0]          divisor,
   output logic                 busy,
   output logic [FRAC_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic [33:0]          rem_ff, rem_in, shifted;
   logic [32:0]          div_ff;
   logic [FRAC_BITS-1:0] q_ff, q_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 ge;

   // dividend < divisor, so the remainder stays below 2^33
   assign shifted = {rem_ff[32:0], 1'b0};
   assign ge      = shifted >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = {1'b0, dividend};
         cnt_in  = CNT_W'(FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? (shifted - {1'b0, div_ff}) : shifted;
         q_in   = {q_ff[FRAC_BITS-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule

@@ rtl/hkp_blend.sv @@
`timescale 1ns / 1ps
// Hermite basis and blend: one shared multiplier, stepped by a small sequencer.
// Depends on hkp_pkg.
module hkp_blend #(
   parameter int FRAC_BITS = hkp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [FRAC_BITS-1:0]  t,
   input  hkp_pkg::key_data_type key0,
   input  logic signed [31:0]    p1_x,
   input  logic signed [31:0]    p1_y,
   output logic                  done,
   output logic signed [31:0]    res_x,
   output logic signed [31:0]    res_y
);

   localparam int MA = 33;
   localparam int HW = FRAC_BITS + 4;
   localparam int PW = MA + HW;
   localparam logic signed [HW-1:0] ONE = HW'(1) << FRAC_BITS;
   localparam logic [3:0] LAST_STEP = 4'd14;

   logic [3:0]               step_ff;
   logic                     busy_ff, done_ff;
   logic signed [MA-1:0]     op_a;
   logic signed [HW-1:0]     op_b;
   logic signed [PW-1:0]     prod_ff;
   logic [FRAC_BITS-1:0]     t_ff, t2_ff, t3_ff;
   logic signed [HW-1:0]     t_s, t2_s, t3_s;
   logic signed [HW-1:0]     h00_ff, h10_ff, h11_ff, h01_ff;
   logic signed [63:0]       acc_ff, prod_ext, rounded, shifted;
   logic signed [31:0]       fin;
   logic signed [31:0]       rx_ff, ry_ff;

   assign t_s  = $signed({4'b0, t_ff});
   assign t2_s = $signed({4'b0, t2_ff});
   assign t3_s = $signed({4'b0, t3_ff});

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         4'd0:  begin op_a = $signed({{(MA-FRAC_BITS){1'b0}}, t_ff});  op_b = t_s; end
         4'd2:  begin op_a = $signed({{(MA-FRAC_BITS){1'b0}}, t2_ff}); op_b = t_s; end
         4'd5:  begin op_a = MA'(key0.point_x);   op_b = h00_ff; end
         4'd6:  begin op_a = MA'(key0.out_tan_x); op_b = h10_ff; end
         4'd7:  begin op_a = MA'(key0.in_tan_x);  op_b = h11_ff; end
         4'd8:  begin op_a = MA'(p1_x);           op_b = h01_ff; end
         4'd9:  begin op_a = MA'(key0.point_y);   op_b = h00_ff; end
         4'd10: begin op_a = MA'(key0.out_tan_y); op_b = h10_ff; end
         4'd11: begin op_a = MA'(key0.in_tan_y);  op_b = h11_ff; end
         4'd12: begin op_a = MA'(p1_y);           op_b = h01_ff; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   assign prod_ext = 64'(prod_ff);

   // divide by 2^F toward zero, then clamp to int32
   assign rounded = acc_ff + (acc_ff[63] ? 64'((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0);
   assign shifted = rounded >>> FRAC_BITS;
   always_comb begin
      if (shifted > hkp_pkg::INT32_MAX_64) begin
         fin = 32'sh7fffffff;
      end else if (shifted < hkp_pkg::INT32_MIN_64) begin
         fin = 32'sh80000000;
      end else begin
         fin = shifted[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 4'd1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (start) begin
         t_ff <= t;
      end
      if (busy_ff) begin
         case (step_ff)
            4'd1: t2_ff <= prod_ff[2*FRAC_BITS-1:FRAC_BITS];
            4'd3: t3_ff <= prod_ff[2*FRAC_BITS-1:FRAC_BITS];
            4'd4: begin
               h00_ff <= (t3_s <<< 1) - (t2_s + (t2_s <<< 1)) + ONE;
               h10_ff <= t3_s - (t2_s <<< 1) + t_s;
               h01_ff <= (t2_s + (t2_s <<< 1)) - (t3_s <<< 1);
               h11_ff <= t3_s - t2_s;
            end
            4'd6:  acc_ff <= prod_ext;
            4'd10: begin
               rx_ff  <= fin;
               acc_ff <= prod_ext;
            end
            4'd14: ry_ff <= fin;
            default: begin
               if (step_ff > 4'd6) begin
                  acc_ff <= acc_ff + prod_ext;
               end
            end
         endcase
      end
   end

   assign done  = done_ff;
   assign res_x = rx_ff;
   assign res_y = ry_ff;

endmodule

@@ rtl/hkp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the keyframe path unit, bound to the top level.
// Depends on hermite_keyframe_path_unit ports.
module hkp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_x,
   input logic        rsp_complete,
   input logic        rsp_table_full
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x))
      else $error("response beat dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_full_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_complete && rsp_out_x == 32'd0)
      else $error("dropped append reported with other fields set");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

endmodule

bind hermite_keyframe_path_unit hkp_checker u_hkp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_out_x      (rsp_if.out_x),
   .rsp_complete   (rsp_if.complete),
   .rsp_table_full (rsp_if.table_full)
);

@@ bench/tb_hermite_keyframe_path_unit.sv @@
`timescale 1ns / 1ps
// Self-checking bench for hermite_keyframe_path_unit: directed rows, then random keyframe
// sequences, checked beat by beat against hand-typed answers or an in-bench Hermite path predictor.
// Depends on rtl/hkp_pkg.sv, rtl/hkp_channels.sv and rtl/hermite_keyframe_path_unit.sv.
module tb_hermite_keyframe_path_unit;

   localparam int KEYS = hkp_pkg::MAX_KEYS_DEFAULT;
   localparam int FRAC = hkp_pkg::FRAC_BITS_DEFAULT;
   // code outside the three defined commands: block must answer all zeros
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1600;
   localparam int CALM_TAIL    = 200;   // last beats are sent with no idling
   localparam int HOLD_AT      = 400;   // response hold-off starts after this many beats
   localparam int HOLD_CYCLES  = 600;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] key_time;
      logic signed [31:0] key_x;
      logic signed [31:0] key_y;
      logic signed [31:0] out_tan_x;
      logic signed [31:0] out_tan_y;
      logic signed [31:0] in_tan_x;
      logic signed [31:0] in_tan_y;
      logic signed [31:0] frame;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } path_req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic               complete;
      logic               table_full;
   } path_rsp_type;

   typedef struct packed {
      path_req_type beat;
      logic         typed;     // expected result written in by hand
      path_rsp_type answer;
   } stim_row_type;

   logic clock;
   logic reset;

   hkp_req_if req_if ();
   hkp_rsp_if rsp_if ();

   hermite_keyframe_path_unit dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Predictor state: a shadow copy of the keyframe table
   // ---------------------------------------------------------------
   int                 shadow_count;
   logic signed [31:0] shadow_time [KEYS];
   logic signed [31:0] shadow_px   [KEYS];
   logic signed [31:0] shadow_py   [KEYS];
   logic signed [31:0] shadow_otx  [KEYS];
   logic signed [31:0] shadow_oty  [KEYS];
   logic signed [31:0] shadow_itx  [KEYS];
   logic signed [31:0] shadow_ity  [KEYS];

   // one axis of the Hermite blend; sum is exact in 64 bits, then
   // truncated toward zero and clamped to int32
   function automatic logic signed [31:0] blend_axis(
      input longint h00, input longint h10, input longint h11, input longint h01,
      input longint p0, input longint ot, input longint it, input longint p1);
      longint acc;
      longint q;
      acc = h00 * p0 + h10 * ot + h11 * it + h01 * p1;
      q = acc / (longint'(1) << FRAC);
      if (q > hkp_pkg::INT32_MAX_64) q = hkp_pkg::INT32_MAX_64;
      if (q < hkp_pkg::INT32_MIN_64) q = hkp_pkg::INT32_MIN_64;
      return q[31:0];
   endfunction

   // expected response for one request beat; updates the shadow table
   function automatic path_rsp_type predict_path(input path_req_type r);
      path_rsp_type res;
      longint f, t_lo, t_hi, d, span, t, t2, t3, one, h00, h10, h01, h11;
      res = '0;
      case (r.command)
         hkp_pkg::CMD_CLEAR: begin
            shadow_count = 0;
         end
         hkp_pkg::CMD_APPEND: begin
            if (shadow_count >= KEYS) begin
               res.table_full = 1'b1;    // full table: key dropped
            end else begin
               shadow_time[shadow_count] = r.key_time;
               shadow_px[shadow_count]   = r.key_x;
               shadow_py[shadow_count]   = r.key_y;
               shadow_otx[shadow_count]  = r.out_tan_x;
               shadow_oty[shadow_count]  = r.out_tan_y;
               shadow_itx[shadow_count]  = r.in_tan_x;
               shadow_ity[shadow_count]  = r.in_tan_y;
               shadow_count++;
            end
         end
         hkp_pkg::CMD_EVAL: begin
            f = r.frame;
            res.out_x = r.pos_x;
            res.out_y = r.pos_y;
            if (shadow_count == 0) res.complete = 1'b1;
            for (int i = 0; i < shadow_count; i++) begin
               t_lo = shadow_time[i];
               if (f < t_lo) break;               // before this key: pass through
               if (i + 1 >= shadow_count) begin   // at or past the last key
                  res.complete = 1'b1;
                  break;
               end
               t_hi = shadow_time[i + 1];
               if (t_hi > f) begin
                  d    = f - t_lo;
                  span = t_hi - t_lo;
                  t    = (d << FRAC) / span;
                  t2   = (t * t) >> FRAC;
                  t3   = (t2 * t) >> FRAC;
                  one  = longint'(1) << FRAC;
                  h00  = 2 * t3 - 3 * t2 + one;
                  h10  = t3 - 2 * t2 + t;
                  h01  = -2 * t3 + 3 * t2;
                  h11  = t3 - t2;
                  res.out_x = blend_axis(h00, h10, h11, h01, shadow_px[i], shadow_otx[i],
                                         shadow_itx[i], shadow_px[i + 1]);
                  res.out_y = blend_axis(h00, h10, h11, h01, shadow_py[i], shadow_oty[i],
                                         shadow_ity[i], shadow_py[i + 1]);
                  break;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus store
   // ---------------------------------------------------------------
   stim_row_type stim_q[$];
   path_rsp_type pending_q[$];
   int           total_beats;
   int           accepted;
   int           returned;
   int           mismatches;

   function automatic path_req_type make_beat(input logic [1:0] cmd, input longint kt,
      input longint kx, input longint ky, input longint fr, input longint px,
      input longint py);
      path_req_type b;
      b.command   = cmd;
      b.key_time  = kt[31:0];
      b.key_x     = kx[31:0];
      b.key_y     = ky[31:0];
      b.out_tan_x = $urandom;
      b.out_tan_y = $urandom;
      b.in_tan_x  = $urandom;
      b.in_tan_y  = $urandom;
      b.frame     = fr[31:0];
      b.pos_x     = px[31:0];
      b.pos_y     = py[31:0];
      return b;
   endfunction

   task automatic add_row(input path_req_type b, input logic typed, input path_rsp_type ans);
      stim_row_type s;
      s.beat = b;
      s.typed = typed;
      s.answer = ans;
      stim_q.push_back(s);
   endtask

   // mostly small values so blends stay in range; sometimes full 32-bit
   function automatic longint pick_value();
      if ($urandom_range(0, 3) == 0) return longint'(signed'($urandom));
      return longint'($urandom_range(0, 4000)) - 2000;
   endfunction

   localparam longint MIN32 = -64'sd2147483648;
   localparam longint MAX32 = 64'sd2147483647;

   task automatic build_directed();
      path_req_type b;
      // evaluate on the empty table after reset: pass through, complete
      b = make_beat(hkp_pkg::CMD_EVAL, 0, 0, 0, 5, MIN32, MAX32);
      add_row(b, 1'b1, '{MIN32[31:0], MAX32[31:0], 1'b1, 1'b0});
      // unused command: all zeros
      b = make_beat(CMD_UNUSED, 7, 8, 9, 10, MAX32, MIN32);
      add_row(b, 1'b1, '0);
      // clear: all zeros
      b = make_beat(hkp_pkg::CMD_CLEAR, 1, 2, 3, 4, -1, -1);
      add_row(b, 1'b1, '0);
      // extreme keys: earliest and latest times, extreme points
      b = make_beat(hkp_pkg::CMD_APPEND, MIN32, MIN32, MAX32, 0, 0, 0);
      b.out_tan_x = 32'h7fffffff; b.in_tan_y = 32'h80000000;
      add_row(b, 1'b1, '0);
      b = make_beat(hkp_pkg::CMD_APPEND, MAX32, MAX32, MIN32, 0, 0, 0);
      add_row(b, 1'b1, '0);
      // frame exactly at the first key
      b = make_beat(hkp_pkg::CMD_EVAL, 0, 0, 0, MIN32, 11, 12);
      add_row(b, 1'b0, '0);
      // middle of the widest possible span (may saturate)
      b = make_beat(hkp_pkg::CMD_EVAL, 0, 0, 0, 0, 11, 12);
      add_row(b, 1'b0, '0);
      b = make_beat(hkp_pkg::CMD_EVAL, 0, 0, 0, MAX32 - 1, 11, 12);
      add_row(b, 1'b0, '0);
      // frame at the last key: pass through, complete
      b = make_beat(hkp_pkg::CMD_EVAL, 0, 0, 0, MAX32, 33, -33);
      add_row(b, 1'b1, '{32'sd33, -32'sd33, 1'b1, 1'b0});
      // frame before the first key: pass through, not complete
      b = make_beat(hkp_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0);
      add_row(b, 1'b1, '0);
      b = make_beat(hkp_pkg::CMD_APPEND, 100, 5, 6, 0, 0, 0);
      add_row(b, 1'b1, '0);
      b = make_beat(hkp_pkg::CMD_EVAL, 0, 0, 0, 50, -7, 7);
      add_row(b, 1'b1, '{-32'sd7, 32'sd7, 1'b0, 1'b0});
      // single key, frame past it
      b = make_beat(hkp_pkg::CMD_EVAL, 0, 0, 0, MAX32, 1, 2);
      add_row(b, 1'b1, '{32'sd1, 32'sd2, 1'b1, 1'b0});
      // keys out of order: scan rules still apply
      b = make_beat(hkp_pkg::CMD_APPEND, 40, 1000, -1000, 0, 0, 0);
      add_row(b, 1'b1, '0);
      b = make_beat(hkp_pkg::CMD_APPEND, 200, -500, 500, 0, 0, 0);
      add_row(b, 1'b1, '0);
      b = make_beat(hkp_pkg::CMD_EVAL, 0, 0, 0, 120, 3, 4);
      add_row(b, 1'b0, '0);
      b = make_beat(hkp_pkg::CMD_EVAL, 0, 0, 0, 150, 3, 4);
      add_row(b, 1'b0, '0);
   endtask

   // well-formed sequences: clear, ascending keys (restarted near zero on overflow), evaluations; plus noise
   task automatic build_random();
      path_req_type b;
      longint       kt, first_t, last_t, fr, v;
      int           n, m, made;
      made = 0;
      while (made < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            b = make_beat(2'($urandom_range(0, 3)), signed'($urandom), signed'($urandom),
                          signed'($urandom), signed'($urandom), signed'($urandom),
                          signed'($urandom));
            add_row(b, 1'b0, '0);
            made++;
         end else begin
            b = make_beat(hkp_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0);
            add_row(b, 1'b0, '0);
            made++;
            // now and then overfill the table
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(KEYS - 2, KEYS + 2)
                                            : $urandom_range(1, 6);
            kt = ($urandom_range(0, 4) == 0) ? longint'(signed'($urandom))
                                             : longint'($urandom_range(0, 2000)) - 1000;
            first_t = kt;
            last_t = kt;
            for (int k = 0; k < n; k++) begin
               b = make_beat(hkp_pkg::CMD_APPEND, kt, pick_value(), pick_value(), 0, 0, 0);
               if ($urandom_range(0, 1) == 1) begin
                  v = pick_value(); b.out_tan_x = v[31:0];
                  v = pick_value(); b.out_tan_y = v[31:0];
                  v = pick_value(); b.in_tan_x  = v[31:0];
                  v = pick_value(); b.in_tan_y  = v[31:0];
               end
               add_row(b, 1'b0, '0);
               made++;
               if (k < KEYS) last_t = kt;
               kt += ($urandom_range(0, 5) == 0) ? longint'($urandom_range(1, 32'h3fffffff))
                                                 : longint'($urandom_range(1, 300));
               if (kt > MAX32) kt = longint'($urandom_range(0, 1000)) - 500;
            end
            m = $urandom_range(2, 8);
            for (int k = 0; k < m; k++) begin
               case ($urandom_range(0, 5))
                  0:       fr = longint'(signed'($urandom));
                  1:       fr = ($urandom_range(0, 1) == 1) ? first_t : last_t;
                  default: fr = first_t - 5 + longint'($urandom) %
                                (last_t - first_t + 11);
               endcase
               if (fr > MAX32) fr = MAX32;
               if (fr < MIN32) fr = MIN32;
               b = make_beat(hkp_pkg::CMD_EVAL, signed'($urandom), signed'($urandom),
                             signed'($urandom), fr, signed'($urandom), signed'($urandom));
               add_row(b, 1'b0, '0);
               made++;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Request driver: random idle bursts, none in the calm tail
   // ---------------------------------------------------------------
   int req_idle;
   int sent;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_idle     <= 0;
         sent         <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_idle > 0) begin
            req_if.valid <= 1'b0;
            req_idle     <= req_idle - 1;
         end else if (sent < total_beats) begin
            req_if.valid     <= 1'b1;
            req_if.command   <= stim_q[sent].beat.command;
            req_if.key_time  <= stim_q[sent].beat.key_time;
            req_if.key_x     <= stim_q[sent].beat.key_x;
            req_if.key_y     <= stim_q[sent].beat.key_y;
            req_if.out_tan_x <= stim_q[sent].beat.out_tan_x;
            req_if.out_tan_y <= stim_q[sent].beat.out_tan_y;
            req_if.in_tan_x  <= stim_q[sent].beat.in_tan_x;
            req_if.in_tan_y  <= stim_q[sent].beat.in_tan_y;
            req_if.frame     <= stim_q[sent].beat.frame;
            req_if.pos_x     <= stim_q[sent].beat.pos_x;
            req_if.pos_y     <= stim_q[sent].beat.pos_y;
            sent             <= sent + 1;
            if (sent < total_beats - CALM_TAIL && $urandom_range(0, 5) == 0)
               req_idle <= $urandom_range(1, 10);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // accepted request beat -> expected response
   always @(posedge clock) begin
      path_req_type b;
      path_rsp_type p;
      if (!reset && req_if.valid && req_if.ready) begin
         b = '{req_if.command, req_if.key_time, req_if.key_x, req_if.key_y,
               req_if.out_tan_x, req_if.out_tan_y, req_if.in_tan_x, req_if.in_tan_y,
               req_if.frame, req_if.pos_x, req_if.pos_y};
         p = predict_path(b);
         // hand-typed rows still run the predictor to keep the shadow table in step
         pending_q.push_back(stim_q[accepted].typed ? stim_q[accepted].answer : p);
         accepted <= accepted + 1;
      end
   end

   // ---------------------------------------------------------------
   // Response sink: random stalls, one long hold-off to back up the input
   // ---------------------------------------------------------------
   int  rsp_stall;
   bit  held_off;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= 0;
         held_off     <= 1'b0;
      end else if (!held_off && accepted >= HOLD_AT) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= HOLD_CYCLES;
         held_off     <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= rsp_stall - 1;
      end else if (accepted < total_beats - CALM_TAIL && $urandom_range(0, 5) == 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= $urandom_range(0, 9);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin
      path_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         returned <= returned + 1;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: x=%0d y=%0d c=%0b f=%0b",
                        rsp_if.out_x, rsp_if.out_y, rsp_if.complete, rsp_if.table_full);
         end else begin
            want = pending_q.pop_front();
            if (rsp_if.out_x !== want.out_x || rsp_if.out_y !== want.out_y ||
                rsp_if.complete !== want.complete ||
                rsp_if.table_full !== want.table_full) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d: want x=%0d y=%0d c=%0b f=%0b, got x=%0d y=%0d c=%0b f=%0b",
                           returned, want.out_x, want.out_y, want.complete,
                           want.table_full, rsp_if.out_x, rsp_if.out_y,
                           rsp_if.complete, rsp_if.table_full);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Run control
   // ---------------------------------------------------------------
   initial begin
      req_if.valid = 1'b0;
      req_if.command = hkp_pkg::CMD_CLEAR;
      req_if.key_time = '0;  req_if.key_x = '0;     req_if.key_y = '0;
      req_if.out_tan_x = '0; req_if.out_tan_y = '0;
      req_if.in_tan_x = '0;  req_if.in_tan_y = '0;
      req_if.frame = '0;     req_if.pos_x = '0;     req_if.pos_y = '0;
      rsp_if.ready = 1'b0;
      shadow_count = 0;
      accepted = 0;
      returned = 0;
      mismatches = 0;
      build_directed();
      build_random();
      total_beats = stim_q.size();
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (accepted == total_beats && pending_q.size() == 0);
      // catch any stray beat
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("hermite_keyframe_path_unit: match");
      else
         $display("hermite_keyframe_path_unit: mismatch");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("hermite_keyframe_path_unit: mismatch");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/hkp_pkg.sv
rtl/hkp_channels.sv
rtl/hkp_key_store.sv
rtl/hkp_divider.sv
rtl/hkp_blend.sv
rtl/hermite_keyframe_path_unit.sv
rtl/hkp_checker.sv
bench/tb_hermite_keyframe_path_unit.sv
